// ----- design/sirad_pkg.sv -----
// ----------------------------------------------------------------------------
// sirad_pkg
// Shared types, constants and helpers for the signed-integer-to-text core.
// ----------------------------------------------------------------------------
package sirad_pkg;

    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 8;
    localparam int DATA_W      = 64;
    localparam int ADDR_W      = 5;
    localparam int REG_SHIFT   = 3;
    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 4;
    localparam int SYM_SLOTS   = 16;
    localparam int DIGIT_CELLS = 32;
    localparam int LEN_W       = $clog2(DIGIT_CELLS + 1);
    localparam int IDX_W       = $clog2(DIGIT_CELLS);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] REG_SYMBOL_COUNT = 2'd0;
    localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    typedef struct packed {
        logic [RADIX_W-1:0]          radix;
        logic [SYM_SLOTS*CHAR_W-1:0] symbols;
    } cfg_t;

    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } work_t;

    function automatic logic [CHAR_W-1:0] sym_at(
        input logic [SYM_SLOTS*CHAR_W-1:0] symbols,
        input logic [DIGIT_W-1:0]          digit
    );
        return symbols[{digit, 3'b000} +: CHAR_W];
    endfunction

    function automatic logic sym_forbidden(input logic [CHAR_W-1:0] c);
        return (c == CH_NUL) || (c == CH_PLUS) || (c == CH_MINUS) ||
               (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

endpackage

// ----- design/signed_int_to_radix_digits_core.sv -----
// ----------------------------------------------------------------------------
// signed_int_to_radix_digits_core
// Prints signed 32-bit words as text in a configured radix and symbol set.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  input     push / full        value[31:0] signed
//  result    empty / pop        out_char[7:0], last
//  config    psel/penable/...   paddr[4:0], pwdata[63:0], prdata[63:0]
//
//  one word leaves the queue, goes through bit-serial conversion in the
//  digit cells, then comes out one character per cycle (up to 33) when
//  results are taken at once
//  reset clears control and config; no clearing pass
//  a stalled result holds the back part; the two-entry queue keeps accepting
//  words with an invalid symbol set are dropped at the front
// ----------------------------------------------------------------------------
module signed_int_to_radix_digits_core #(
    parameter int MAX_SYMBOLS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [sirad_pkg::ADDR_W-1:0]         paddr,
    input  logic [sirad_pkg::DATA_W-1:0]         pwdata,
    output logic [sirad_pkg::DATA_W-1:0]         prdata,
    output logic                                 pready,
    input  logic                                 push,
    input  logic signed [sirad_pkg::VALUE_W-1:0] value,
    output logic                                 full,
    output logic [sirad_pkg::CHAR_W-1:0]         out_char,
    output logic                                 last,
    output logic                                 empty,
    input  logic                                 pop
);

    sirad_pkg::cfg_t  cfg;
    sirad_pkg::work_t q_data;
    sirad_pkg::work_t q_dout;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;

    sirad_front #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .push    (push),
        .value   (value),
        .full    (full),
        .q_push  (q_push),
        .q_data  (q_data),
        .q_full  (q_full),
        .cfg     (cfg)
    );

    sirad_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_data  (q_data),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_dout  (q_dout),
        .q_empty (q_empty)
    );

    sirad_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_empty  (q_empty),
        .q_dout   (q_dout),
        .q_pop    (q_pop),
        .out_char (out_char),
        .last     (last),
        .empty    (empty),
        .pop      (pop)
    );

endmodule

// ----- design/sirad_front.sv -----
// ----------------------------------------------------------------------------
// sirad_front
// Register file, symbol set check and input classification.
// ----------------------------------------------------------------------------
module sirad_front #(
    parameter int MAX_SYMBOLS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sirad_pkg::ADDR_W-1:0]        paddr,
    input  logic [sirad_pkg::DATA_W-1:0]        pwdata,
    output logic [sirad_pkg::DATA_W-1:0]        prdata,
    output logic                                pready,
    input  logic                                push,
    input  logic signed [sirad_pkg::VALUE_W-1:0] value,
    output logic                                full,
    output logic                                q_push,
    output sirad_pkg::work_t                    q_data,
    input  logic                                q_full,
    output sirad_pkg::cfg_t                     cfg
);

    logic [sirad_pkg::RADIX_W-1:0] count_reg;
    logic [sirad_pkg::DATA_W-1:0]  sym_low_reg;
    logic [sirad_pkg::DATA_W-1:0]  sym_high_reg;
    logic [1:0]                    reg_idx;
    logic                          wr_en;
    logic                          set_ok;
    logic [sirad_pkg::VALUE_W-1:0] raw;

    assign pready  = 1'b1;
    assign reg_idx = paddr[sirad_pkg::ADDR_W-1:sirad_pkg::REG_SHIFT];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            sym_low_reg  <= '0;
            sym_high_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                sirad_pkg::REG_SYMBOL_COUNT: count_reg    <= pwdata[sirad_pkg::RADIX_W-1:0];
                sirad_pkg::REG_SYMBOLS_LOW:  sym_low_reg  <= pwdata;
                sirad_pkg::REG_SYMBOLS_HIGH: sym_high_reg <= pwdata;
                default:                     count_reg    <= count_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            sirad_pkg::REG_SYMBOL_COUNT: prdata = {{(sirad_pkg::DATA_W-sirad_pkg::RADIX_W){1'b0}},
                                                   count_reg};
            sirad_pkg::REG_SYMBOLS_LOW:  prdata = sym_low_reg;
            sirad_pkg::REG_SYMBOLS_HIGH: prdata = sym_high_reg;
            default:                     prdata = '0;
        endcase
    end

    assign cfg.radix   = count_reg;
    assign cfg.symbols = {sym_high_reg, sym_low_reg};

    // symbol set check: range, forbidden bytes, repeats
    always_comb
    begin
        set_ok = (count_reg >= sirad_pkg::RADIX_W'(2)) &&
                 (count_reg <= sirad_pkg::RADIX_W'(MAX_SYMBOLS));
        for (int i = 0; i < sirad_pkg::SYM_SLOTS; i++)
        begin
            if (sirad_pkg::RADIX_W'(i) < count_reg)
            begin
                if (sirad_pkg::sym_forbidden(cfg.symbols[i*sirad_pkg::CHAR_W +: sirad_pkg::CHAR_W]))
                begin
                    set_ok = 1'b0;
                end
                for (int j = i + 1; j < sirad_pkg::SYM_SLOTS; j++)
                begin
                    if ((sirad_pkg::RADIX_W'(j) < count_reg) &&
                        (cfg.symbols[i*sirad_pkg::CHAR_W +: sirad_pkg::CHAR_W] ==
                         cfg.symbols[j*sirad_pkg::CHAR_W +: sirad_pkg::CHAR_W]))
                    begin
                        set_ok = 1'b0;
                    end
                end
            end
        end
    end

    assign raw        = value;
    assign full       = q_full;
    assign q_push     = push && !q_full && set_ok;
    assign q_data.neg = raw[sirad_pkg::VALUE_W-1];
    assign q_data.mag = raw[sirad_pkg::VALUE_W-1] ? (sirad_pkg::VALUE_W'(0) - raw) : raw;

endmodule

// ----- design/sirad_queue.sv -----
// ----------------------------------------------------------------------------
// sirad_queue
// Short queue of classified words between front and back.
// ----------------------------------------------------------------------------
module sirad_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_push,
    input  sirad_pkg::work_t q_data,
    output logic             q_full,
    input  logic             q_pop,
    output sirad_pkg::work_t q_dout,
    output logic             q_empty
);

    localparam int PTR_W = $clog2(sirad_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(sirad_pkg::QUEUE_DEPTH + 1);

    sirad_pkg::work_t  mem [0:sirad_pkg::QUEUE_DEPTH-1];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign q_full  = (count_reg == CNT_W'(sirad_pkg::QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_push = q_push && !q_full;
    assign do_pop  = q_pop && !q_empty;
    assign q_dout  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= q_data;
        end
    end

endmodule

// ----- design/sirad_back.sv -----
// ----------------------------------------------------------------------------
// sirad_back
// Bit-serial conversion into digit cells, then character output.
// ----------------------------------------------------------------------------
module sirad_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sirad_pkg::cfg_t              cfg,
    input  logic                         q_empty,
    input  sirad_pkg::work_t             q_dout,
    output logic                         q_pop,
    output logic [sirad_pkg::CHAR_W-1:0] out_char,
    output logic                         last,
    output logic                         empty,
    input  logic                         pop
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam int CELLS  = sirad_pkg::DIGIT_CELLS;
    localparam int LEVELS = $clog2(CELLS + 1);
    localparam int CNT_W  = $clog2(sirad_pkg::VALUE_W);

    logic [1:0]                      state_reg, state_next;
    logic [sirad_pkg::VALUE_W-1:0]   mag_reg;
    logic [sirad_pkg::DIGIT_W-1:0]   cell_reg [0:CELLS-1];
    logic [sirad_pkg::DIGIT_W-1:0]   cell_new [0:CELLS-1];
    logic [sirad_pkg::LEN_W-1:0]     len_reg, len_next, len_step;
    logic [CNT_W-1:0]                bit_cnt_reg, bit_cnt_next;
    logic [sirad_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic                            sign_reg, sign_next;
    logic                            out_valid_reg, out_valid_next;
    logic [sirad_pkg::CHAR_W-1:0]    out_char_reg, out_char_next;
    logic                            last_reg, last_next;
    logic                            load, shift, out_free;
    logic [CELLS:0]                  g_lvl [0:LEVELS];
    logic [CELLS:0]                  p_lvl [0:LEVELS];
    logic [CELLS:0]                  carry;
    logic [sirad_pkg::RADIX_W-1:0]   t;

    // carry lookahead across digit cells: generate when 2d >= radix,
    // propagate when 2d + 1 == radix
    always_comb
    begin
        g_lvl[0][0] = mag_reg[sirad_pkg::VALUE_W-1];
        p_lvl[0][0] = 1'b0;
        for (int i = 0; i < CELLS; i++)
        begin
            g_lvl[0][i+1] = ({cell_reg[i], 1'b0} >= cfg.radix);
            p_lvl[0][i+1] = ({cell_reg[i], 1'b1} == cfg.radix);
        end
        for (int l = 0; l < LEVELS; l++)
        begin
            for (int j = 0; j <= CELLS; j++)
            begin
                if (j >= (1 << l))
                begin
                    g_lvl[l+1][j] = g_lvl[l][j] | (p_lvl[l][j] & g_lvl[l][j-(1 << l)]);
                    p_lvl[l+1][j] = p_lvl[l][j] & p_lvl[l][j-(1 << l)];
                end
                else
                begin
                    g_lvl[l+1][j] = g_lvl[l][j];
                    p_lvl[l+1][j] = p_lvl[l][j];
                end
            end
        end
        carry = g_lvl[LEVELS];
    end

    always_comb
    begin
        t = '0;
        for (int i = 0; i < CELLS; i++)
        begin
            t = {cell_reg[i], carry[i]};
            if (carry[i+1])
            begin
                cell_new[i] = sirad_pkg::DIGIT_W'(t - cfg.radix);
            end
            else
            begin
                cell_new[i] = t[sirad_pkg::DIGIT_W-1:0];
            end
        end
    end

    assign len_step = len_reg + sirad_pkg::LEN_W'(carry[len_reg]);
    assign out_free = !out_valid_reg || pop;

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        bit_cnt_next   = bit_cnt_reg;
        idx_next       = idx_reg;
        sign_next      = sign_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        q_pop          = 1'b0;
        load           = 1'b0;
        shift          = 1'b0;
        if (out_valid_reg && pop)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop        = 1'b1;
                    load         = 1'b1;
                    sign_next    = q_dout.neg;
                    len_next     = sirad_pkg::LEN_W'(1);
                    bit_cnt_next = '0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                shift        = 1'b1;
                len_next     = len_step;
                bit_cnt_next = bit_cnt_reg + CNT_W'(1);
                if (bit_cnt_reg == CNT_W'(sirad_pkg::VALUE_W - 1))
                begin
                    idx_next   = sirad_pkg::IDX_W'(len_step - sirad_pkg::LEN_W'(1));
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (sign_reg)
                    begin
                        out_char_next = sirad_pkg::CH_MINUS;
                        last_next     = 1'b0;
                        sign_next     = 1'b0;
                    end
                    else
                    begin
                        out_char_next = sirad_pkg::sym_at(cfg.symbols, cell_reg[idx_reg]);
                        last_next     = (idx_reg == '0);
                        if (idx_reg == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg - sirad_pkg::IDX_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            bit_cnt_reg   <= '0;
            idx_reg       <= '0;
            sign_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            bit_cnt_reg   <= bit_cnt_next;
            idx_reg       <= idx_next;
            sign_reg      <= sign_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
        if (load)
        begin
            mag_reg <= q_dout.mag;
            for (int i = 0; i < CELLS; i++)
            begin
                cell_reg[i] <= '0;
            end
        end
        else if (shift)
        begin
            mag_reg <= {mag_reg[sirad_pkg::VALUE_W-2:0], 1'b0};
            for (int i = 0; i < CELLS; i++)
            begin
                cell_reg[i] <= cell_new[i];
            end
        end
    end

    assign out_char = out_char_reg;
    assign last     = last_reg;
    assign empty    = !out_valid_reg;

endmodule

// ----- design/sirad_checker.sv -----
// ----------------------------------------------------------------------------
// sirad_checker
// Port-level checks for the signed-integer-to-text core.
// ----------------------------------------------------------------------------
module sirad_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 psel,
    input logic                                 penable,
    input logic                                 pwrite,
    input logic [sirad_pkg::ADDR_W-1:0]         paddr,
    input logic [sirad_pkg::DATA_W-1:0]         pwdata,
    input logic [sirad_pkg::DATA_W-1:0]         prdata,
    input logic                                 pready,
    input logic                                 push,
    input logic signed [sirad_pkg::VALUE_W-1:0] value,
    input logic                                 full,
    input logic [sirad_pkg::CHAR_W-1:0]         out_char,
    input logic                                 last,
    input logic                                 empty,
    input logic                                 pop
);

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_char) && $stable(last)))
        else $error("result word changed while stalled");

    // the sign is never the final character
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (out_char == sirad_pkg::CH_MINUS)) |-> !last)
        else $error("sign marked as final character");

    // nothing pending once reset has taken effect
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> (empty && !full))
        else $error("queue flags wrong in reset");

    // symbol count reads back what was written
    a_count_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && (paddr == '0)) |=>
        ((paddr != '0) ||
         (prdata == {{(sirad_pkg::DATA_W-sirad_pkg::RADIX_W){1'b0}},
                     $past(pwdata[sirad_pkg::RADIX_W-1:0])})))
        else $error("symbol count readback mismatch");

endmodule

bind signed_int_to_radix_digits_core sirad_checker u_sirad_checker (.*);
